### src/rucst_pkg.sv
// shared constants, types and helpers for the ray unit cube slab test
package rucst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int NUM_W     = WORD_W + 1;
  localparam int DIVD_W    = NUM_W + FRAC_BITS;
  localparam int MAG_W     = DIVD_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int THR_W     = 16;
  localparam int NUM_AXES  = 3;
  localparam int STAGES    = DIV_STEPS + 2;

  localparam logic signed [WORD_W-1:0] POS_INF = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] NEG_INF = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [WORD_W-1:0] lo;
    logic signed [WORD_W-1:0] hi;
  } slab_span_t;

  // saturate a signed quotient to the word range
  function automatic logic signed [WORD_W-1:0] sat_word(
    input logic signed [MAG_W:0] v
  );
    logic signed [MAG_W:0] pmax;
    logic signed [MAG_W:0] nmin;
    pmax = {{(MAG_W-WORD_W+2){1'b0}}, {(WORD_W-1){1'b1}}};
    nmin = {{(MAG_W-WORD_W+2){1'b1}}, {(WORD_W-1){1'b0}}};
    if (v > pmax) begin
      sat_word = POS_INF;
    end else if (v < nmin) begin
      sat_word = NEG_INF;
    end else begin
      sat_word = v[WORD_W-1:0];
    end
  endfunction

endpackage

### src/ray_unit_cube_slab_test_top.sv
// top level of the ray against unit cube slab test
// One ray a beat, signed fixed point, tested against the cube -1..+1 on each
// axis. Three axis lanes each run two restoring dividers, one quotient bit
// per stage; a ray passes the lane load stage, division steps and span
// register, then the merge register. A new ray is taken every cycle unless
// out_ready low holds the output beat: the whole pipe moves as one and halts
// only then, so the sustained rate is one ray per cycle. parallel_threshold
// resets to 7; the user must write it through cfg_wr_en/cfg_wr_data while
// the pipe is empty, and the block itself does not enforce this.
module ray_unit_cube_slab_test_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rucst_pkg::THR_W-1:0]         cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rucst_pkg::WORD_W-1:0] in_origin_x,
  input  logic signed [rucst_pkg::WORD_W-1:0] in_origin_y,
  input  logic signed [rucst_pkg::WORD_W-1:0] in_origin_z,
  input  logic signed [rucst_pkg::WORD_W-1:0] in_dir_x,
  input  logic signed [rucst_pkg::WORD_W-1:0] in_dir_y,
  input  logic signed [rucst_pkg::WORD_W-1:0] in_dir_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic signed [rucst_pkg::WORD_W-1:0] out_t_near,
  output logic signed [rucst_pkg::WORD_W-1:0] out_t_far
);
  import rucst_pkg::*;

  logic [THR_W-1:0]  thr_r;
  logic [STAGES:0]   vld_r;
  logic              adv;
  slab_span_t        spans [NUM_AXES];
  logic signed [WORD_W-1:0] org [NUM_AXES];
  logic signed [WORD_W-1:0] dir [NUM_AXES];

  // the pipe moves whenever the last stage is empty or being drained
  assign adv      = !vld_r[STAGES] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[STAGES];

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(7);
      vld_r <= '0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      // valid shadow of the lane stages plus the merge register
      if (adv) vld_r <= {vld_r[STAGES-1:0], in_valid};
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    rucst_axis_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .origin (org[g]),
      .dir    (dir[g]),
      .thr    (thr_r),
      .span   (spans[g])
    );
  end

  rucst_merge u_merge (
    .clk    (clk),
    .adv    (adv),
    .spans  (spans),
    .hit    (out_hit),
    .t_near (out_t_near),
    .t_far  (out_t_far)
  );

endmodule

### src/rucst_axis_lane.sv
// one axis lane: two pipelined restoring dividers for entry and exit times
module rucst_axis_lane (
  input  logic                               clk,
  input  logic                               adv,
  input  logic signed [rucst_pkg::WORD_W-1:0] origin,
  input  logic signed [rucst_pkg::WORD_W-1:0] dir,
  input  logic [rucst_pkg::THR_W-1:0]         thr,
  output rucst_pkg::slab_span_t              span
);
  import rucst_pkg::*;

  // per-numerator pipeline contents
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] quo;
    logic [MAG_W-1:0] dvd;
    logic             neg;
    logic             num_pos;
    logic             num_zero;
  } div_st_t;

  div_st_t          a_r [STAGES-1];
  div_st_t          b_r [STAGES-1];
  logic [MAG_W-1:0] den_r [STAGES-2];
  logic             par_r [STAGES-1];
  slab_span_t       span_r;
  slab_span_t       span_nxt;

  logic signed [NUM_W-1:0] num_a;
  logic signed [NUM_W-1:0] num_b;
  logic [WORD_W:0]         dmag;
  logic                    par_in;
  div_st_t                 a_in;
  div_st_t                 b_in;

  function automatic div_st_t load(input logic signed [NUM_W-1:0] n,
                                   input logic dneg);
    div_st_t         s;
    logic [NUM_W-1:0] m;
    m = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    s.rem      = '0;
    s.quo      = '0;
    s.dvd      = {m, {FRAC_BITS{1'b0}}};
    s.neg      = n[NUM_W-1] ^ dneg;
    s.num_pos  = !n[NUM_W-1] && (n != '0);
    s.num_zero = (n == '0);
    return s;
  endfunction

  // one restoring division step
  function automatic div_st_t step(input div_st_t s, input logic [MAG_W-1:0] den);
    div_st_t      o;
    logic [MAG_W:0] t;
    o = s;
    t = {s.rem, s.dvd[MAG_W-1]};
    o.dvd = {s.dvd[MAG_W-2:0], 1'b0};
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      o.quo = {s.quo[MAG_W-2:0], 1'b1};
    end else begin
      o.quo = {s.quo[MAG_W-2:0], 1'b0};
    end
    o.rem = t[MAG_W-1:0];
    return o;
  endfunction

  function automatic logic signed [WORD_W-1:0] finish(input div_st_t s, input logic par,
                                                      input logic zero_pos);
    logic signed [MAG_W:0] q;
    if (par) begin
      if (s.num_pos)       finish = POS_INF;
      else if (s.num_zero) finish = zero_pos ? POS_INF : NEG_INF;
      else                 finish = NEG_INF;
    end else begin
      q = s.neg ? -$signed({1'b0, s.quo}) : $signed({1'b0, s.quo});
      finish = sat_word(q);
    end
  endfunction

  always_comb begin
    num_a  = -NUM_W'(signed'(1 <<< FRAC_BITS)) - NUM_W'(origin);
    num_b  =  NUM_W'(signed'(1 <<< FRAC_BITS)) - NUM_W'(origin);
    dmag   = dir[WORD_W-1] ? (WORD_W+1)'(-NUM_W'(dir)) : (WORD_W+1)'(NUM_W'(dir));
    par_in = (dir == '0) || (dmag < (WORD_W+1)'(thr));
    a_in   = load(num_a, dir[WORD_W-1]);
    b_in   = load(num_b, dir[WORD_W-1]);
  end

  logic signed [WORD_W-1:0] ta;
  logic signed [WORD_W-1:0] tb;

  // signed times and ordering of the pair, registered in the last lane stage
  always_comb begin
    ta = finish(a_r[STAGES-2], par_r[STAGES-2], 1'b0);
    tb = finish(b_r[STAGES-2], par_r[STAGES-2], 1'b1);
    if (ta > tb) begin
      span_nxt.lo = tb;
      span_nxt.hi = ta;
    end else begin
      span_nxt.lo = ta;
      span_nxt.hi = tb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0]   <= a_in;
      b_r[0]   <= b_in;
      den_r[0] <= MAG_W'(dmag);
      par_r[0] <= par_in;
      for (int i = 1; i < STAGES - 1; i++) begin
        a_r[i]   <= step(a_r[i-1], den_r[i-1]);
        b_r[i]   <= step(b_r[i-1], den_r[i-1]);
        par_r[i] <= par_r[i-1];
      end
      for (int i = 1; i < STAGES - 2; i++) begin
        den_r[i] <= den_r[i-1];
      end
      span_r <= span_nxt;
    end
  end

  assign span = span_r;

endmodule

### src/rucst_merge.sv
// merge of the three axis spans into entry, exit and hit
module rucst_merge (
  input  logic                               clk,
  input  logic                               adv,
  input  rucst_pkg::slab_span_t              spans [rucst_pkg::NUM_AXES],
  output logic                               hit,
  output logic signed [rucst_pkg::WORD_W-1:0] t_near,
  output logic signed [rucst_pkg::WORD_W-1:0] t_far
);
  import rucst_pkg::*;

  logic signed [WORD_W-1:0] near_nxt;
  logic signed [WORD_W-1:0] far_nxt;
  logic signed [WORD_W-1:0] near_r;
  logic signed [WORD_W-1:0] far_r;

  always_comb begin
    near_nxt = spans[0].lo;
    far_nxt  = spans[0].hi;
    for (int i = 1; i < NUM_AXES; i++) begin
      if (spans[i].lo > near_nxt) near_nxt = spans[i].lo;
      if (spans[i].hi < far_nxt)  far_nxt  = spans[i].hi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
    end
  end

  assign t_near = near_r;
  assign t_far  = far_r;
  assign hit    = (near_r <= far_r);

endmodule

### src/rucst_checker.sv
// port-level checks for the slab test top level
module rucst_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic signed [31:0] out_t_near,
  input logic signed [31:0] out_t_far
);
  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_t_near <= out_t_far)))
    else $error("hit flag disagrees with times");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_t_near) && $stable(out_t_far))
    else $error("output beat changed while stalled");
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
endmodule

bind ray_unit_cube_slab_test_top rucst_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_t_near(out_t_near), .out_t_far(out_t_far)
);
